// ===== hw/rtl/utf8dec_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8dec_pkg
// shared types and constants for the utf-8 to ucs-2 decoder
// ----------------------------------------------------------------------------
package utf8dec_pkg;

  localparam int unsigned MaxUnits = 4;
  localparam int unsigned CntW     = $clog2(MaxUnits + 1);
  localparam int unsigned IdxW     = $clog2(MaxUnits);

  localparam logic [1:0] TagCont = 2'b10;
  localparam logic [1:0] TagLead = 2'b11;
  localparam logic [2:0] TagLong = 3'b111;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } out_beat_t;

  typedef struct packed {
    out_beat_t [MaxUnits-1:0] unit;
    logic      [CntW-1:0]     cnt;
  } bundle_t;

endpackage

// ===== hw/rtl/utf8_to_ucs2_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder
// utf-8 byte stream to 16-bit ucs-2 code units
// ----------------------------------------------------------------------------
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_ready_o  | in_data_i  (in_byte, end_of_text)
// out     | output    | out_valid_o/out_ready_i| out_data_o (code_unit, last_unit)
//
// one byte is taken per cycle while the result register is free or the byte gives
// no units; a byte giving n units (n from 0 to 4) is sent as n beats, so the
// output beat register sets the rate; a byte passes the input then the result register
// reset clears the held byte count and all valid flags
// stalls on the output back up through the result register to in_ready_o
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder import utf8dec_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  in_beat_t in_q;
  logic     in_vld_q;
  bundle_t  bnd;
  logic     free, take;

  assign take       = in_vld_q && (bnd.cnt == '0 || free);
  assign in_ready_o = !in_vld_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  utf8dec_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (in_q),
    .take_i (take),
    .bnd_o  (bnd)
  );

  utf8dec_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && bnd.cnt != '0),
    .bnd_i       (bnd),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hw/rtl/utf8dec_decode.sv =====
// ----------------------------------------------------------------------------
// utf8dec_decode
// held-byte state and single-pass decode of one byte into a bundle of units
// ----------------------------------------------------------------------------
module utf8dec_decode import utf8dec_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_beat_t beat_i,
  input  logic     take_i,
  output bundle_t  bnd_o
);

  logic [1:0] cnt_q, cnt_d;
  logic [7:0] lead_q, lead_d;
  logic [7:0] sec_q, sec_d;

  logic [7:0] b;
  logic       is_zero, is_cont, is_lead;
  logic [CntW-1:0] n;
  out_beat_t [MaxUnits-1:0] units;

  assign b       = beat_i.in_byte;
  assign is_zero = (b == 8'h00);
  assign is_cont = (b[7:6] == TagCont);
  assign is_lead = (b[7:6] == TagLead);

  always_comb begin
    n      = '0;
    units  = '0;
    cnt_d  = cnt_q;
    lead_d = lead_q;
    sec_d  = sec_q;
    if (!is_zero) begin
      if (cnt_q == 2'd0) begin
        if (is_lead) begin
          cnt_d  = 2'd1;
          lead_d = b;
        end else begin
          units[n[IdxW-1:0]] = '{code_unit: {8'h00, b}, last_unit: 1'b0};
          n = n + 1'b1;
        end
      end else if (cnt_q == 2'd1) begin
        if (is_cont && lead_q[7:5] == TagLong) begin
          cnt_d = 2'd2;
          sec_d = b;
        end else if (is_cont) begin
          units[n[IdxW-1:0]] = '{code_unit: {5'b0, lead_q[4:0], b[5:0]}, last_unit: 1'b0};
          n = n + 1'b1;
          cnt_d = 2'd0;
        end else begin
          units[n[IdxW-1:0]] = '{code_unit: {8'h00, lead_q}, last_unit: 1'b0};
          n = n + 1'b1;
          cnt_d = 2'd0;
          if (is_lead) begin
            cnt_d  = 2'd1;
            lead_d = b;
          end else begin
            units[n[IdxW-1:0]] = '{code_unit: {8'h00, b}, last_unit: 1'b0};
            n = n + 1'b1;
          end
        end
      end else begin
        if (is_cont) begin
          units[n[IdxW-1:0]] = '{code_unit: {lead_q[3:0], sec_q[5:0], b[5:0]},
                                 last_unit: 1'b0};
          n = n + 1'b1;
          cnt_d = 2'd0;
        end else begin
          units[n[IdxW-1:0]] = '{code_unit: {8'h00, lead_q}, last_unit: 1'b0};
          n = n + 1'b1;
          units[n[IdxW-1:0]] = '{code_unit: {8'h00, sec_q}, last_unit: 1'b0};
          n = n + 1'b1;
          cnt_d = 2'd0;
          if (is_lead) begin
            cnt_d  = 2'd1;
            lead_d = b;
          end else begin
            units[n[IdxW-1:0]] = '{code_unit: {8'h00, b}, last_unit: 1'b0};
            n = n + 1'b1;
          end
        end
      end
    end
    // flush held bytes and terminate
    if (is_zero || beat_i.end_of_text) begin
      if (cnt_d != 2'd0) begin
        units[n[IdxW-1:0]] = '{code_unit: {8'h00, lead_d}, last_unit: 1'b0};
        n = n + 1'b1;
      end
      if (cnt_d[1]) begin
        units[n[IdxW-1:0]] = '{code_unit: {8'h00, sec_d}, last_unit: 1'b0};
        n = n + 1'b1;
      end
      cnt_d = 2'd0;
      units[n[IdxW-1:0]] = '{code_unit: 16'h0000, last_unit: 1'b1};
      n = n + 1'b1;
    end
  end

  assign bnd_o = '{unit: units, cnt: n};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (take_i) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      lead_q <= lead_d;
      sec_q  <= sec_d;
    end
  end

endmodule

// ===== hw/rtl/utf8dec_serial.sv =====
// ----------------------------------------------------------------------------
// utf8dec_serial
// result register holding one bundle, sent out one beat per cycle while out_ready_i is high
// ----------------------------------------------------------------------------
module utf8dec_serial import utf8dec_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  bundle_t   bnd_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  bundle_t         bnd_q;
  logic [IdxW-1:0] idx_q;
  logic            vld_q;
  logic            fire, is_last;

  assign fire        = vld_q && out_ready_i;
  assign is_last     = ({1'b0, idx_q} == bnd_q.cnt - 1'b1);
  assign free_o      = !vld_q || (fire && is_last);
  assign out_valid_o = vld_q;
  assign out_data_o  = bnd_q.unit[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (load_i) begin
      vld_q <= 1'b1;
      idx_q <= '0;
    end else if (fire) begin
      if (is_last) begin
        vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bnd_q <= bnd_i;
    end
  end

endmodule
